/* hdl/max_pool_3x3_stride2_pad1_core_macros.svh */
// assertion macros shared by the pooling core rtl
// no dependencies; included by the modules that carry assertions
`ifndef MAX_POOL_3X3_STRIDE2_PAD1_CORE_MACROS_SVH
`define MAX_POOL_3X3_STRIDE2_PAD1_CORE_MACROS_SVH

// condition and consequence checked in the same cycle
`define MP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked in the cycle after the condition
`define MP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/mpool_pkg.sv */
// shared types and constants of the 3x3 stride-2 max pooling core
// no dependencies
package mpool_pkg;

   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int COL_COUNT_W     = 8;
   localparam int ROW_COUNT_W     = 8;
   localparam int CHANNEL_COUNT_W = 7;

   localparam logic [COL_COUNT_W-1:0]     COL_COUNT_RESET     = 8'd112;
   localparam logic [ROW_COUNT_W-1:0]     ROW_COUNT_RESET     = 8'd112;
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 7'd64;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      REG_COL_COUNT     = 2'd0,
      REG_ROW_COUNT     = 2'd1,
      REG_CHANNEL_COUNT = 2'd2
   } reg_index_type;

   // classification of one sample, made by the front
   typedef struct packed {
      logic row_first;
      logic row_odd;
      logic col_first;
      logic col_odd;
      logic frame_last;
   } cmd_flags_type;

endpackage

/* hdl/mpool_csr.sv */
// configuration registers behind the apb-style port, with count saturation
// depends on mpool_pkg
module mpool_csr import mpool_pkg::*; #(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_HEIGHT   = 128,
   parameter int MAX_CHANNELS = 64,
   localparam int NCOL_W = $clog2(MAX_WIDTH + 1),
   localparam int NROW_W = $clog2(MAX_HEIGHT + 1),
   localparam int NCH_W  = $clog2(MAX_CHANNELS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [NCOL_W-1:0]     col_num,
   output logic [NROW_W-1:0]     row_num,
   output logic [NCH_W-1:0]      ch_num
);

   logic [COL_COUNT_W-1:0]     col_count_ff, col_count_in;
   logic [ROW_COUNT_W-1:0]     row_count_ff, row_count_in;
   logic [CHANNEL_COUNT_W-1:0] channel_count_ff, channel_count_in;
   logic                       wr_en;
   reg_index_type              reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      col_count_in     = col_count_ff;
      row_count_in     = row_count_ff;
      channel_count_in = channel_count_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_COL_COUNT:     col_count_in     = csr_pwdata[COL_COUNT_W-1:0];
            REG_ROW_COUNT:     row_count_in     = csr_pwdata[ROW_COUNT_W-1:0];
            REG_CHANNEL_COUNT: channel_count_in = csr_pwdata[CHANNEL_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff     <= COL_COUNT_RESET;
         row_count_ff     <= ROW_COUNT_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
      end else begin
         col_count_ff     <= col_count_in;
         row_count_ff     <= row_count_in;
         channel_count_ff <= channel_count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_index)
         REG_COL_COUNT:     csr_prdata = CSR_DATA_W'(col_count_ff);
         REG_ROW_COUNT:     csr_prdata = CSR_DATA_W'(row_count_ff);
         REG_CHANNEL_COUNT: csr_prdata = CSR_DATA_W'(channel_count_ff);
         default: ;
      endcase
   end

   // clamp each count into one..max
   always_comb begin
      if (col_count_ff == '0)               col_num = NCOL_W'(1);
      else if (32'(col_count_ff) > MAX_WIDTH) col_num = NCOL_W'(MAX_WIDTH);
      else                                  col_num = NCOL_W'(col_count_ff);

      if (row_count_ff == '0)                row_num = NROW_W'(1);
      else if (32'(row_count_ff) > MAX_HEIGHT) row_num = NROW_W'(MAX_HEIGHT);
      else                                   row_num = NROW_W'(row_count_ff);

      if (channel_count_ff == '0)                  ch_num = NCH_W'(1);
      else if (32'(channel_count_ff) > MAX_CHANNELS) ch_num = NCH_W'(MAX_CHANNELS);
      else                                         ch_num = NCH_W'(channel_count_ff);
   end

endmodule

/* hdl/mpool_front.sv */
// front end: accepts samples, tracks channel, column and row, classifies each sample
// depends on mpool_pkg
module mpool_front import mpool_pkg::*; #(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_HEIGHT   = 128,
   parameter int MAX_CHANNELS = 64,
   parameter int SAMPLE_BITS  = 16,
   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int NCOL_W = $clog2(MAX_WIDTH + 1),
   localparam int NROW_W = $clog2(MAX_HEIGHT + 1),
   localparam int NCH_W  = $clog2(MAX_CHANNELS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic [NCOL_W-1:0]      col_num,
   input  logic [NROW_W-1:0]      row_num,
   input  logic [NCH_W-1:0]       ch_num,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [SAMPLE_BITS-1:0] cmd_sample,
   output logic [COL_W-1:0]       cmd_col,
   output logic [CH_W-1:0]        cmd_ch,
   output cmd_flags_type          cmd_flags
);

   logic [CH_W-1:0]  ch_pos_ff, ch_pos_in;
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;
   logic [CH_W:0]    ch_inc;
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;
   logic [NCOL_W-1:0] col_even_num;
   logic [NROW_W-1:0] row_even_num;
   logic             last_ch, last_col, last_row;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   assign ch_inc  = (CH_W + 1)'(ch_pos_ff) + 1'b1;
   assign col_inc = (COL_W + 1)'(col_pos_ff) + 1'b1;
   assign row_inc = (ROW_W + 1)'(row_pos_ff) + 1'b1;

   // a position at or past the last value of its count wraps at the next advance
   always_comb begin
      ch_pos_in  = ch_pos_ff;
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (q_push) begin
         if (32'(ch_inc) >= 32'(ch_num)) begin
            ch_pos_in = '0;
            if (32'(col_inc) >= 32'(col_num)) begin
               col_pos_in = '0;
               if (32'(row_inc) >= 32'(row_num)) row_pos_in = '0;
               else                              row_pos_in = row_inc[ROW_W-1:0];
            end else begin
               col_pos_in = col_inc[COL_W-1:0];
            end
         end else begin
            ch_pos_in = ch_inc[CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_pos_ff  <= '0;
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         ch_pos_ff  <= ch_pos_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // last window sits on the last odd row and column; an odd count drops its tail
   assign col_even_num = {col_num[NCOL_W-1:1], 1'b0};
   assign row_even_num = {row_num[NROW_W-1:1], 1'b0};
   assign last_ch  = (32'(ch_pos_ff) + 32'd1) == 32'(ch_num);
   assign last_col = (32'(col_pos_ff) + 32'd1) == 32'(col_even_num);
   assign last_row = (32'(row_pos_ff) + 32'd1) == 32'(row_even_num);

   assign cmd_sample           = req_sample;
   assign cmd_col              = col_pos_ff;
   assign cmd_ch               = ch_pos_ff;
   assign cmd_flags.row_first  = (row_pos_ff == '0);
   assign cmd_flags.row_odd    = row_pos_ff[0];
   assign cmd_flags.col_first  = (col_pos_ff == '0);
   assign cmd_flags.col_odd    = col_pos_ff[0];
   assign cmd_flags.frame_last = last_ch && last_col && last_row;

endmodule

/* hdl/mpool_queue.sv */
// short first-in first-out queue between front and back
// depends on mpool_pkg
module mpool_queue import mpool_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic             full
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (32'(count_ff) == DEPTH);
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wdata;
   end

endmodule

/* hdl/mpool_back.sv */
// back end: running-maximum read-modify-write on the row and column stores, result register
// depends on mpool_pkg and the assertion macro header
`include "max_pool_3x3_stride2_pad1_core_macros.svh"

module mpool_back import mpool_pkg::*; #(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_CHANNELS = 64,
   parameter int SAMPLE_BITS  = 16,
   localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int ROW_DEPTH = MAX_WIDTH * (1 << CH_W)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  logic [SAMPLE_BITS-1:0] q_sample,
   input  logic [COL_W-1:0]       q_col,
   input  logic [CH_W-1:0]        q_ch,
   input  cmd_flags_type          q_flags,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_max_value,
   output logic                   rsp_frame_last
);

   logic [SAMPLE_BITS-1:0] row_mem [ROW_DEPTH];
   logic [SAMPLE_BITS-1:0] col_mem [MAX_CHANNELS];

   logic                          a_valid_ff, a_valid_in;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic [COL_W+CH_W-1:0]         a_addr_ff;
   logic [CH_W-1:0]               a_ch_ff;
   cmd_flags_type                 a_flags_ff;
   logic signed [SAMPLE_BITS-1:0] a_row_rd_ff;
   logic signed [SAMPLE_BITS-1:0] a_col_rd_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]        rsp_max_ff;
   logic                          rsp_last_ff;

   logic [COL_W+CH_W-1:0]         q_addr;
   logic signed [SAMPLE_BITS-1:0] row_prev, vert, row_wr, col_prev, col_wr, result;
   logic                          emit, row_we, col_we, adv;

   assign q_addr = {q_col, q_ch};

   // window arithmetic; padding contributes zero on the first row and column
   always_comb begin
      row_prev = a_flags_ff.row_first ? '0 : a_row_rd_ff;
      vert     = (a_row_rd_ff > a_sample_ff) ? a_row_rd_ff : a_sample_ff;
      if (a_flags_ff.row_odd) row_wr = a_sample_ff;
      else                    row_wr = (row_prev > a_sample_ff) ? row_prev : a_sample_ff;
      col_prev = a_flags_ff.col_first ? '0 : a_col_rd_ff;
      if (a_flags_ff.col_odd) col_wr = vert;
      else                    col_wr = (col_prev > vert) ? col_prev : vert;
      result   = (a_col_rd_ff > vert) ? a_col_rd_ff : vert;
   end

   assign emit   = a_valid_ff && a_flags_ff.row_odd && a_flags_ff.col_odd;
   assign row_we = a_valid_ff;
   assign col_we = a_valid_ff && a_flags_ff.row_odd;
   // the stage only holds when its result cannot enter the output register
   assign adv    = !(emit && rsp_valid_ff && !rsp_ready);
   assign q_pop  = adv && !q_empty;

   assign a_valid_in   = adv ? !q_empty : a_valid_ff;
   assign rsp_valid_in = (adv && emit) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && row_we) row_mem[a_addr_ff] <= row_wr;
      if (adv && col_we) col_mem[a_ch_ff]   <= col_wr;
   end

   // store reads forward the write of the item ahead when addresses meet
   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_sample_ff <= q_sample;
         a_addr_ff   <= q_addr;
         a_ch_ff     <= q_ch;
         a_flags_ff  <= q_flags;
         if (row_we && a_addr_ff == q_addr) a_row_rd_ff <= row_wr;
         else                               a_row_rd_ff <= row_mem[q_addr];
         if (col_we && a_ch_ff == q_ch)     a_col_rd_ff <= col_wr;
         else                               a_col_rd_ff <= col_mem[q_ch];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && emit) begin
         rsp_max_ff  <= result;
         rsp_last_ff <= a_flags_ff.frame_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_max_value  = rsp_max_ff;
   assign rsp_frame_last = rsp_last_ff;

   `MP_ASSERT_NEXT(a_hold_on_stall, clock, reset, !adv, a_valid_ff && $stable(a_addr_ff), "stalled item lost")
   `MP_ASSERT_NEXT(emit_reaches_out, clock, reset, adv && emit, rsp_valid_ff && rsp_max_ff == $past(result), "result not registered")
   `MP_ASSERT_NOW(last_on_corner, clock, reset, a_valid_ff && a_flags_ff.frame_last, a_flags_ff.row_odd && a_flags_ff.col_odd, "frame end off window corner")

endmodule

/* hdl/max_pool_3x3_stride2_pad1_core.sv */
// 3x3 max pooling at stride 2 with a one-sample zero border, top level
// depends on mpool_pkg, mpool_csr, mpool_front, mpool_queue, mpool_back
//
// Samples enter one per transfer in row-major order with channels interleaved per column;
// a result leaves for every sample on an odd row and odd column, and the sustained rate
// is one sample per clock while the result side does not stall. A sample passes the queue
// and the store-read stage register; its result then sits in the output register. That
// path is set by the read-modify-write of the per-column row-pair store, whose registered
// read is forwarded from the preceding item's write. After a stall on the result side has
// filled the queue, the input side waits for room. The stores need no clearing after reset.
// The user must write counts only between frames, and the block itself does not enforce
// it; col_count and row_count are expected even, else the trailing partial window is dropped.
module max_pool_3x3_stride2_pad1_core import mpool_pkg::*; #(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_HEIGHT   = 128,
   parameter int MAX_CHANNELS = 64,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_max_value,
   output logic                   rsp_frame_last,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NCOL_W = $clog2(MAX_WIDTH + 1);
   localparam int NROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
   localparam int Q_W    = SAMPLE_BITS + COL_W + CH_W + $bits(cmd_flags_type);

   logic [NCOL_W-1:0]      col_num;
   logic [NROW_W-1:0]      row_num;
   logic [NCH_W-1:0]       ch_num;
   logic                   q_full, q_empty, q_push, q_pop;
   logic [SAMPLE_BITS-1:0] cmd_sample, q_sample;
   logic [COL_W-1:0]       cmd_col, q_col;
   logic [CH_W-1:0]        cmd_ch, q_ch;
   cmd_flags_type          cmd_flags, q_flags;
   logic [Q_W-1:0]         q_wdata, q_rdata;

   mpool_csr #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .col_num     (col_num),
      .row_num     (row_num),
      .ch_num      (ch_num)
   );

   mpool_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .col_num    (col_num),
      .row_num    (row_num),
      .ch_num     (ch_num),
      .q_full     (q_full),
      .q_push     (q_push),
      .cmd_sample (cmd_sample),
      .cmd_col    (cmd_col),
      .cmd_ch     (cmd_ch),
      .cmd_flags  (cmd_flags)
   );

   assign q_wdata = {cmd_sample, cmd_col, cmd_ch, cmd_flags};
   assign {q_sample, q_col, q_ch, q_flags} = q_rdata;

   mpool_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .full  (q_full)
   );

   mpool_back #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_sample       (q_sample),
      .q_col          (q_col),
      .q_ch           (q_ch),
      .q_flags        (q_flags),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_max_value  (rsp_max_value),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

/* test/max_pool_3x3_stride2_pad1_core_test.sv */
// self-checking testbench for the 3x3 stride-2 max pooling core
// needs mpool_pkg and the core rtl; feeds whole frames, predicts each pooled result
// and checks it against the result port, with the frame shape set over the csr port
`timescale 1ns / 100ps

module max_pool_3x3_stride2_pad1_core_test import mpool_pkg::*;;

   localparam int MAX_W       = 128;
   localparam int MAX_H       = 128;
   localparam int MAX_CH      = 64;
   localparam int SB          = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PRINT_LIMIT = 100;

   typedef struct {
      logic [SB-1:0] max_value;
      logic          frame_last;
   } pool_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SB-1:0]         req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SB-1:0]         rsp_max_value;
   logic                  rsp_frame_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   max_pool_3x3_stride2_pad1_core #(
      .MAX_WIDTH(MAX_W),
      .MAX_HEIGHT(MAX_H),
      .MAX_CHANNELS(MAX_CH),
      .SAMPLE_BITS(SB)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_max_value(rsp_max_value),
      .rsp_frame_last(rsp_frame_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shape of the frame as last written to the core
   int cfg_cols  = COL_COUNT_RESET;
   int cfg_rows  = ROW_COUNT_RESET;
   int cfg_chans = CHANNEL_COUNT_RESET;

   // running maxima and scan position of the pooling predictor
   logic signed [SB-1:0] pair_rows [MAX_W*MAX_CH];
   logic signed [SB-1:0] pair_cols [MAX_CH];
   int pool_chan = 0;
   int pool_col  = 0;
   int pool_row  = 0;

   pool_result_type pool_expected [$];
   logic [SB-1:0]   pending_samples [$];
   pool_result_type want;

   int  issued_count   = 0;
   int  accepted_count = 0;
   int  mismatches     = 0;
   int  cycle_count    = 0;
   int  req_gap        = 0;
   int  rsp_gap        = 0;
   bit  idle_on        = 1'b0;
   bit  req_done       = 1'b0;

   function automatic int clamp_count(int v, int hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic logic signed [SB-1:0] smax(logic signed [SB-1:0] a,
                                                 logic signed [SB-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic int frame_size();
      return clamp_count(cfg_cols, MAX_W) * clamp_count(cfg_rows, MAX_H) *
             clamp_count(cfg_chans, MAX_CH);
   endfunction

   task automatic report_mismatch(string what, int got, int exp_val);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                  what, cycle_count, got, exp_val);
      mismatches++;
   endtask

   // one accepted sample: update the running maxima, maybe produce a pooled result
   task automatic pool_predict(input logic [SB-1:0] raw);
      int ncol, nrow, nch, idx, last_row, last_col;
      logic signed [SB-1:0] s, prev, vert;
      pool_result_type r;
      ncol = clamp_count(cfg_cols, MAX_W);
      nrow = clamp_count(cfg_rows, MAX_H);
      nch  = clamp_count(cfg_chans, MAX_CH);
      idx  = pool_col * MAX_CH + pool_chan;
      s    = raw;
      if (pool_row % 2 == 0) begin
         prev = (pool_row == 0) ? '0 : pair_rows[idx];
         pair_rows[idx] = smax(prev, s);
      end else begin
         vert = smax(pair_rows[idx], s);
         pair_rows[idx] = s;
         if (pool_col % 2 == 0) begin
            // left border brings in the zero padding
            prev = (pool_col == 0) ? '0 : pair_cols[pool_chan];
            pair_cols[pool_chan] = smax(prev, vert);
         end else begin
            last_row = (nrow & ~1) - 1;
            last_col = (ncol & ~1) - 1;
            r.max_value  = smax(pair_cols[pool_chan], vert);
            r.frame_last = (pool_row == last_row) && (pool_col == last_col) &&
                           (pool_chan == nch - 1);
            pair_cols[pool_chan] = vert;
            pool_expected.push_back(r);
         end
      end
      pool_chan++;
      if (pool_chan >= nch) begin
         pool_chan = 0;
         pool_col++;
         if (pool_col >= ncol) begin
            pool_col = 0;
            pool_row++;
            if (pool_row >= nrow) pool_row = 0;
         end
      end
   endtask

   // sender: one item per transfer, random gaps between items
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_samples.size() > 0) begin
            req_valid  <= 1'b1;
            req_sample <= pending_samples.pop_front();
            if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 12);
      end
   end

   // monitor: predict on each input transfer, check each result transfer
   always @(posedge clock) begin
      if (reset) begin
         req_done <= 1'b0;
      end else begin
         req_done <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            pool_predict(req_sample);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pool_expected.size() == 0) begin
               report_mismatch("unexpected result", int'($signed(rsp_max_value)), 0);
            end else begin
               want = pool_expected.pop_front();
               if (rsp_max_value !== want.max_value)
                  report_mismatch("max_value", int'($signed(rsp_max_value)),
                                  int'($signed(want.max_value)));
               if (rsp_frame_last !== want.frame_last)
                  report_mismatch("frame_last", rsp_frame_last, want.frame_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_count != issued_count || pool_expected.size() != 0);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(reg_index_type idx, logic [CSR_DATA_W-1:0] exp_val,
                            logic [CSR_DATA_W-1:0] mask);
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if ((got & mask) !== (exp_val & mask))
         report_mismatch(idx.name(), int'(got & mask), int'(exp_val & mask));
   endtask

   // shape changes only between frames, once the core has gone quiet
   task automatic set_frame(int cols, int rows, int chans);
      wait_drained();
      repeat (8) @(negedge clock);
      csr_write(REG_COL_COUNT, cols);
      csr_write(REG_ROW_COUNT, rows);
      csr_write(REG_CHANNEL_COUNT, chans);
      cfg_cols  = cols;
      cfg_rows  = rows;
      cfg_chans = chans;
      csr_check(REG_COL_COUNT, cols, 32'hff);
      csr_check(REG_ROW_COUNT, rows, 32'hff);
      csr_check(REG_CHANNEL_COUNT, chans, 32'h7f);
   endtask

   task automatic push_sample(logic [SB-1:0] v);
      pending_samples.push_back(v);
      issued_count++;
   endtask

   function automatic logic [SB-1:0] pick_sample(bit neg_only);
      logic [SB-1:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'h8000;
         1: v = 16'h7fff;
         2: v = SB'($urandom_range(0, 8)) - SB'(4);
         3: v = '0;
         default: v = SB'($urandom);
      endcase
      if (neg_only) v[SB-1] = 1'b1;
      return v;
   endfunction

   // one whole frame; a split frame stalls halfway until every result is out
   task automatic send_frame(bit split);
      int n;
      bit neg_only;
      n = frame_size();
      neg_only = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
         if (split && i == n / 2) wait_drained();
         push_sample(pick_sample(neg_only));
      end
   endtask

   initial begin
      int frames;
      bit big;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_check(REG_COL_COUNT, COL_COUNT_RESET, 32'hff);
      csr_check(REG_ROW_COUNT, ROW_COUNT_RESET, 32'hff);
      csr_check(REG_CHANNEL_COUNT, CHANNEL_COUNT_RESET, 32'h7f);

      // smallest frame: window touches padding, so a zero wins over negatives
      set_frame(2, 2, 1);
      push_sample(16'h8000);
      push_sample(16'hffff);
      push_sample(16'hfffb);
      push_sample(16'h8000);
      push_sample(16'h7fff);
      push_sample(16'h0000);
      push_sample(16'h0001);
      push_sample(16'h8000);
      // 4x4 all most-negative: only the inner window is free of padding
      set_frame(4, 4, 1);
      for (int i = 0; i < 16; i++) begin
         if (i == 8) wait_drained();
         push_sample(16'h8000);
      end

      // count extremes, including zero and out-of-range values that saturate
      idle_on = 1'b1;
      set_frame(128, 2, 1);
      send_frame(1'b0);
      set_frame(2, 128, 1);
      send_frame(1'b0);
      set_frame(2, 2, 64);
      send_frame(1'b1);
      set_frame(255, 0, 0);
      send_frame(1'b0);
      set_frame(1, 255, 0);
      send_frame(1'b0);
      set_frame(0, 0, 127);
      send_frame(1'b0);

      while (issued_count < 1350) begin
         idle_on = (issued_count < 1250) && ($urandom_range(0, 3) != 0);
         frames = $urandom_range(1, 3);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
               set_frame(2 * $urandom_range(1, 8), 2 * $urandom_range(1, 4),
                         $urandom_range(1, 4));
            // odd counts drop the trailing partial window
            6, 7:
               set_frame($urandom_range(1, 9), $urandom_range(1, 7), $urandom_range(1, 3));
            8: begin
               big = $urandom_range(0, 1);
               frames = 1;
               if (big)
                  set_frame($urandom_range(129, 255), $urandom_range(0, 2),
                            $urandom_range(0, 1));
               else
                  set_frame($urandom_range(0, 2), $urandom_range(0, 3),
                            $urandom_range(0, 1) ? 0 : $urandom_range(65, 127));
            end
            default: begin
               frames = 1;
               set_frame(2, 2, $urandom_range(5, 64));
            end
         endcase
         repeat (frames) begin
            send_frame($urandom_range(0, 4) == 0);
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (pool_expected.size() != 0)
         report_mismatch("results missing", 0, pool_expected.size());
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
